FILE: hdl/keyed_datagram_header_parser_top_assert.svh
// Assertion macros for the keyed datagram header parser.
`ifndef KEYED_DATAGRAM_HEADER_PARSER_TOP_ASSERT_SVH
`define KEYED_DATAGRAM_HEADER_PARSER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define KDHP_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: label");

// Condition implies consequence in the next cycle.
`define KDHP_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: label");

`endif

FILE: hdl/kdhp_pkg.sv
// ----------------------------------------------------------------------------
// Keyed datagram header parser package
// Transaction payload types and the result and status codes.
// ----------------------------------------------------------------------------
package kdhp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } kdhp_req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [7:0]         payload_byte;
      logic [2:0]         status_code;
      logic signed [31:0] part_key;
      logic signed [63:0] time_stamp;
      logic               last_result;
   } kdhp_rsp_type;

   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_VALUE   = 2'd2;
   localparam logic [1:0] KIND_VERDICT = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNC     = 3'd1;
   localparam logic [2:0] ST_FLAGS     = 3'd2;
   localparam logic [2:0] ST_TOPIC_SZ  = 3'd3;
   localparam logic [2:0] ST_KEY_SZ    = 3'd4;
   localparam logic [2:0] ST_VALUE_SZ  = 3'd5;
   localparam logic [2:0] ST_MISMATCH  = 3'd6;

endpackage

FILE: hdl/keyed_datagram_header_parser_top.sv
// Results enter the three-entry result queue the cycle after their byte is
// accepted; rsp_ offers them in order. One byte per cycle while req_ready is
// high; a body byte that also ends the datagram yields two results, and
// req_ready is high whenever the queue has room for two results.
// Reset (synchronous, active high) empties the queue and returns the parser
// to the first flags byte with all held fields cleared.
// ----------------------------------------------------------------------------
// Keyed datagram header parser
// Walks the datagram layout one byte per transaction, passes body bytes out
// tagged by kind and gives a verdict with partition key and timestamp.
// ----------------------------------------------------------------------------
module keyed_datagram_header_parser_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kdhp_pkg::kdhp_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kdhp_pkg::kdhp_rsp_type rsp_data
);
   import kdhp_pkg::*;

   `include "keyed_datagram_header_parser_top_assert.svh"

   typedef enum logic [3:0] {
      PH_FLAGS, PH_PKEY, PH_TSZ, PH_TOPIC, PH_TS, PH_KSZ, PH_KEY, PH_VSZ,
      PH_VALUE, PH_DONE, PH_IGNORE
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [31:0]  left_ff, left_in, left_dec;
   logic [63:0]  shift_ff, shift_in, shifted;
   logic [31:0]  key_ff, key_in;
   logic [63:0]  stamp_ff, stamp_in;
   logic [2:0]   err_ff, err_in;
   logic [2:0]   verdict_status;
   logic         body_valid;
   logic [1:0]   body_kind;
   logic         accept, pop, field_end;

   kdhp_rsp_type q_ff [3];
   kdhp_rsp_type q_in [3];
   kdhp_rsp_type new0, new1;
   logic [1:0]   cnt_ff, cnt_in, cnt_pop, n_push;

   assign accept    = req_valid && req_ready;
   assign req_ready = (cnt_ff <= 2'd1);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && rsp_ready;

   assign shifted   = {shift_ff[55:0], req_data.data_byte};
   assign left_dec  = (left_ff != 32'd0) ? left_ff - 32'd1 : 32'd0;
   assign field_end = (left_dec == 32'd0);

   // Parser next state for one accepted byte.
   always_comb begin
      phase_in       = phase_ff;
      left_in        = left_ff;
      shift_in       = shift_ff;
      key_in         = key_ff;
      stamp_in       = stamp_ff;
      err_in         = err_ff;
      body_valid     = 1'b0;
      body_kind      = KIND_TOPIC;
      verdict_status = ST_OK;
      if (accept) begin
         case (phase_ff)
            PH_FLAGS, PH_PKEY, PH_TSZ, PH_TS, PH_KSZ, PH_VSZ: begin
               shift_in = shifted;
               left_in  = left_dec;
            end
            PH_TOPIC: begin
               body_valid = 1'b1;
               body_kind  = KIND_TOPIC;
               left_in    = left_dec;
            end
            PH_KEY: begin
               body_valid = 1'b1;
               body_kind  = KIND_KEY;
               left_in    = left_dec;
            end
            PH_VALUE: begin
               body_valid = 1'b1;
               body_kind  = KIND_VALUE;
               left_in    = left_dec;
            end
            PH_DONE: begin
               // A byte beyond the declared value length.
               err_in   = ST_MISMATCH;
               phase_in = PH_IGNORE;
               left_in  = 32'd0;
            end
            default: begin
            end
         endcase

         if (field_end && (phase_ff inside {PH_FLAGS, PH_PKEY, PH_TSZ, PH_TOPIC,
                                            PH_TS, PH_KSZ, PH_KEY, PH_VSZ,
                                            PH_VALUE})) begin
            shift_in = 64'd0;
            case (phase_ff)
               PH_FLAGS: begin
                  if (shifted[15:0] != 16'd0) begin
                     err_in   = ST_FLAGS;
                     phase_in = PH_IGNORE;
                     left_in  = 32'd0;
                  end else begin
                     phase_in = PH_PKEY;
                     left_in  = 32'd4;
                  end
               end
               PH_PKEY: begin
                  key_in   = shifted[31:0];
                  phase_in = PH_TSZ;
                  left_in  = 32'd2;
               end
               PH_TSZ: begin
                  if (shifted[15:0] == 16'd0 || shifted[15]) begin
                     err_in   = ST_TOPIC_SZ;
                     phase_in = PH_IGNORE;
                     left_in  = 32'd0;
                  end else begin
                     phase_in = PH_TOPIC;
                     left_in  = {16'd0, shifted[15:0]};
                  end
               end
               PH_TOPIC: begin
                  phase_in = PH_TS;
                  left_in  = 32'd8;
               end
               PH_TS: begin
                  stamp_in = shifted;
                  phase_in = PH_KSZ;
                  left_in  = 32'd4;
               end
               PH_KSZ: begin
                  if (shifted[31]) begin
                     err_in   = ST_KEY_SZ;
                     phase_in = PH_IGNORE;
                     left_in  = 32'd0;
                  end else if (shifted[31:0] == 32'd0) begin
                     phase_in = PH_VSZ;
                     left_in  = 32'd4;
                  end else begin
                     phase_in = PH_KEY;
                     left_in  = shifted[31:0];
                  end
               end
               PH_KEY: begin
                  phase_in = PH_VSZ;
                  left_in  = 32'd4;
               end
               PH_VSZ: begin
                  if (shifted[31]) begin
                     err_in   = ST_VALUE_SZ;
                     phase_in = PH_IGNORE;
                     left_in  = 32'd0;
                  end else if (shifted[31:0] == 32'd0) begin
                     phase_in = PH_DONE;
                     left_in  = 32'd0;
                  end else begin
                     phase_in = PH_VALUE;
                     left_in  = shifted[31:0];
                  end
               end
               PH_VALUE: begin
                  phase_in = PH_DONE;
                  left_in  = 32'd0;
               end
               default: begin
               end
            endcase
         end

         if (err_in != ST_OK) begin
            verdict_status = err_in;
         end else if (phase_in == PH_DONE) begin
            verdict_status = ST_OK;
         end else if (phase_in == PH_VALUE) begin
            verdict_status = ST_MISMATCH;
         end else begin
            verdict_status = ST_TRUNC;
         end
      end
   end

   // Results of this transaction, body byte first.
   always_comb begin
      kdhp_rsp_type body_rsp, verdict_rsp;
      body_rsp.result_kind  = body_kind;
      body_rsp.payload_byte = req_data.data_byte;
      body_rsp.status_code  = ST_OK;
      body_rsp.part_key     = '0;
      body_rsp.time_stamp   = '0;
      body_rsp.last_result  = !req_data.last_byte;

      verdict_rsp.result_kind  = KIND_VERDICT;
      verdict_rsp.payload_byte = 8'd0;
      verdict_rsp.status_code  = verdict_status;
      verdict_rsp.part_key     = key_in;
      verdict_rsp.time_stamp   = stamp_in;
      verdict_rsp.last_result  = 1'b1;

      new0   = body_valid ? body_rsp : verdict_rsp;
      new1   = verdict_rsp;
      n_push = accept ? ({1'b0, body_valid} + {1'b0, req_data.last_byte}) : 2'd0;
   end

   // Result queue: pop from the head, then append behind what remains.
   always_comb begin
      q_in = q_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
      end
      cnt_pop = cnt_ff - {1'b0, pop};
      for (int i = 0; i < 3; i++) begin
         if (n_push != 2'd0 && 2'(i) == cnt_pop) begin
            q_in[i] = new0;
         end
         if (n_push == 2'd2 && 2'(i) == 2'(cnt_pop + 2'd1)) begin
            q_in[i] = new1;
         end
      end
      cnt_in = cnt_pop + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAGS;
         left_ff  <= 32'd2;
         shift_ff <= 64'd0;
         key_ff   <= 32'd0;
         stamp_ff <= 64'd0;
         err_ff   <= ST_OK;
         cnt_ff   <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept && req_data.last_byte) begin
            phase_ff <= PH_FLAGS;
            left_ff  <= 32'd2;
            shift_ff <= 64'd0;
            key_ff   <= 32'd0;
            stamp_ff <= 64'd0;
            err_ff   <= ST_OK;
         end else begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            shift_ff <= shift_in;
            key_ff   <= key_in;
            stamp_ff <= stamp_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   `KDHP_ASSERT_SAME(a_ignore_has_error, clock, reset, phase_ff == PH_IGNORE, err_ff != ST_OK)
   `KDHP_ASSERT_NEXT(a_last_restarts, clock, reset, accept && req_data.last_byte, phase_ff == PH_FLAGS && left_ff == 32'd2 && err_ff == ST_OK)
   `KDHP_ASSERT_NEXT(a_last_gives_verdict, clock, reset, accept && req_data.last_byte, rsp_valid)
   `KDHP_ASSERT_SAME(a_body_has_count, clock, reset, phase_ff == PH_TOPIC || phase_ff == PH_KEY || phase_ff == PH_VALUE, left_ff != 32'd0)

endmodule

FILE: tb/tb_keyed_datagram_header_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed datagram header parser testbench
// Streams datagrams into the parser and checks every body byte and verdict
// against a behavioral copy of the parser. The sender idles in bursts, the
// receiver stalls on its own pattern, and any mismatch is reported.
// ----------------------------------------------------------------------------
module tb_keyed_datagram_header_parser_top;
   import kdhp_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int RANDOM_BYTES = 350;

   typedef enum logic [3:0] {
      SEG_FLAGS, SEG_PKEY, SEG_TSZ, SEG_TOPIC, SEG_STAMP, SEG_KSZ,
      SEG_KEY, SEG_VSZ, SEG_VALUE, SEG_DONE, SEG_SKIP
   } parse_seg_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   kdhp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   kdhp_rsp_type rsp_data;

   // Parser state as the block should hold it.
   parse_seg_type seg        = SEG_FLAGS;
   logic [31:0]  seg_left   = 32'd2;
   logic [63:0]  acc        = '0;
   logic [31:0]  held_key   = '0;
   logic [63:0]  held_stamp = '0;
   logic [2:0]   first_err  = ST_OK;

   kdhp_rsp_type expected_rsp_q[$];
   logic [7:0]   frame_q[$];
   int           mismatches   = 0;
   int           parsed_bytes = 0;
   int           cycle_count  = 0;
   int           burst_left   = 0;
   int           stall_mode   = 0;
   int           stall_span   = 0;

   keyed_datagram_header_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: each stretch picks a stall style and holds it for a while.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 300);
      end else begin
         stall_span = stall_span - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (cycle_count[1:0] == 2'd0);
         default: rsp_ready <= ((stall_span % 8) < 5);
      endcase
   end

   // ---------------------------------------------------------------- predictor
   function automatic void enter_seg(parse_seg_type next, logic [31:0] count);
      seg      = next;
      seg_left = count;
      acc      = '0;
   endfunction

   function automatic void abort_frame(logic [2:0] code);
      first_err = code;
      seg       = SEG_SKIP;
      seg_left  = '0;
   endfunction

   function automatic void clear_parser();
      enter_seg(SEG_FLAGS, 32'd2);
      held_key   = '0;
      held_stamp = '0;
      first_err  = ST_OK;
   endfunction

   // Size and flags checks happen as soon as the field's final byte is in.
   function automatic void close_field();
      logic [31:0] sz;
      case (seg)
         SEG_FLAGS: begin
            if (acc[15:0] != 16'd0) abort_frame(ST_FLAGS);
            else enter_seg(SEG_PKEY, 32'd4);
         end
         SEG_PKEY: begin
            held_key = acc[31:0];
            enter_seg(SEG_TSZ, 32'd2);
         end
         SEG_TSZ: begin
            sz = {16'd0, acc[15:0]};
            if (sz == 0 || sz[15]) abort_frame(ST_TOPIC_SZ);
            else enter_seg(SEG_TOPIC, sz);
         end
         SEG_TOPIC: enter_seg(SEG_STAMP, 32'd8);
         SEG_STAMP: begin
            held_stamp = acc;
            enter_seg(SEG_KSZ, 32'd4);
         end
         SEG_KSZ: begin
            sz = acc[31:0];
            if (sz[31]) abort_frame(ST_KEY_SZ);
            else if (sz == 0) enter_seg(SEG_VSZ, 32'd4);
            else enter_seg(SEG_KEY, sz);
         end
         SEG_KEY: enter_seg(SEG_VSZ, 32'd4);
         SEG_VSZ: begin
            sz = acc[31:0];
            if (sz[31]) abort_frame(ST_VALUE_SZ);
            else if (sz == 0) enter_seg(SEG_DONE, 32'd0);
            else enter_seg(SEG_VALUE, sz);
         end
         SEG_VALUE: enter_seg(SEG_DONE, 32'd0);
         default: ;
      endcase
   endfunction

   function automatic void predict_byte(kdhp_req_type req);
      kdhp_rsp_type outs[2];
      int           n;
      n = 0;
      case (seg)
         SEG_FLAGS, SEG_PKEY, SEG_TSZ, SEG_STAMP, SEG_KSZ, SEG_VSZ: begin
            acc = {acc[55:0], req.data_byte};
            if (seg_left != 0) seg_left = seg_left - 1;
            if (seg_left == 0) close_field();
         end
         SEG_TOPIC, SEG_KEY, SEG_VALUE: begin
            outs[n] = '0;
            outs[n].result_kind  = (seg == SEG_TOPIC) ? KIND_TOPIC :
                                   (seg == SEG_KEY) ? KIND_KEY : KIND_VALUE;
            outs[n].payload_byte = req.data_byte;
            n++;
            if (seg_left != 0) seg_left = seg_left - 1;
            if (seg_left == 0) close_field();
         end
         SEG_DONE: abort_frame(ST_MISMATCH);
         default: ;
      endcase
      if (req.last_byte) begin
         outs[n] = '0;
         outs[n].result_kind = KIND_VERDICT;
         if (first_err != ST_OK) outs[n].status_code = first_err;
         else if (seg == SEG_DONE) outs[n].status_code = ST_OK;
         else if (seg == SEG_VALUE) outs[n].status_code = ST_MISMATCH;
         else outs[n].status_code = ST_TRUNC;
         outs[n].part_key   = held_key;
         outs[n].time_stamp = held_stamp;
         n++;
         clear_parser();
      end
      if (n > 0) outs[n-1].last_result = 1'b1;
      for (int i = 0; i < n; i++) expected_rsp_q.push_back(outs[i]);
   endfunction

   // ----------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_result(input kdhp_rsp_type got);
      kdhp_rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch("result with nothing outstanding, kind",
                         64'(got.result_kind), 64'd0);
         return;
      end
      want = expected_rsp_q.pop_front();
      if (got.result_kind !== want.result_kind)
         report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      if (got.payload_byte !== want.payload_byte)
         report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      if (got.status_code !== want.status_code)
         report_mismatch("status_code", 64'(got.status_code), 64'(want.status_code));
      if (got.part_key !== want.part_key)
         report_mismatch("part_key", 64'(got.part_key), 64'(want.part_key));
      if (got.time_stamp !== want.time_stamp)
         report_mismatch("time_stamp", got.time_stamp, want.time_stamp);
      if (got.last_result !== want.last_result)
         report_mismatch("last_result", 64'(got.last_result), 64'(want.last_result));
   endtask

   // Prediction comes first: a result never leaves on the edge its byte enters.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            parsed_bytes++;
            predict_byte(req_data);
         end
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
   end

   // ------------------------------------------------------------------ sending
   task automatic send_byte(input logic [7:0] data, input logic last);
      req_valid           <= 1'b1;
      req_data.data_byte  <= data;
      req_data.last_byte  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 15);
      end
   endtask

   function automatic void put_be(logic [63:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_noise(int count);
      for (int i = 0; i < count; i++) frame_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void build_frame(logic [15:0] flags, logic [31:0] pkey,
                                       logic [15:0] tsz, logic [63:0] stamp,
                                       logic [31:0] ksz, logic [31:0] vsz,
                                       int topic_n, int key_n, int val_n);
      put_be(64'(flags), 2);
      put_be(64'(pkey), 4);
      put_be(64'(tsz), 2);
      put_noise(topic_n);
      put_be(stamp, 8);
      put_be(64'(ksz), 4);
      put_noise(key_n);
      put_be(64'(vsz), 4);
      put_noise(val_n);
   endfunction

   function automatic void build_clean_frame(int topic_n, int key_n, int val_n);
      build_frame(16'd0, $urandom, 16'(topic_n), {$urandom, $urandom},
                  32'(key_n), 32'(val_n), topic_n, key_n, val_n);
   endfunction

   // Sends the first keep bytes of the built frame (all when keep is zero),
   // marking the final one sent as the end of the datagram.
   task automatic send_frame(input int keep);
      int total;
      total = (keep > 0 && keep < frame_q.size()) ? keep : frame_q.size();
      for (int i = 0; i < total; i++) send_byte(frame_q[i], i == total - 1);
      frame_q.delete();
   endtask

   // -------------------------------------------------------------------- tests
   task automatic test_clean_frames();
      build_frame(16'd0, 32'h8000_0000, 16'd1, 64'h8000_0000_0000_0000,
                  32'd0, 32'd0, 1, 0, 0);
      send_frame(0);
      build_frame(16'd0, 32'h7FFF_FFFF, 16'd3, 64'h7FFF_FFFF_FFFF_FFFF,
                  32'd2, 32'd3, 3, 2, 3);
      send_frame(0);
      build_frame(16'd0, 32'hFFFF_FFFF, 16'd2, '1, 32'd1, 32'd1, 2, 1, 1);
      send_frame(0);
      build_frame(16'd0, 32'd0, 16'd1, 64'd0, 32'd0, 32'd2, 1, 0, 2);
      send_frame(0);
   endtask

   task automatic test_header_errors();
      // Bytes after the flags error are ignored until the datagram ends.
      build_frame(16'h0001, $urandom, 16'd1, {$urandom, $urandom}, 32'd1, 32'd1, 1, 1, 1);
      send_frame(0);
      // A check that fails on the final byte reports its own error.
      build_frame(16'h8000, $urandom, 16'd1, {$urandom, $urandom}, 32'd0, 32'd0, 1, 0, 0);
      send_frame(2);
      build_frame(16'hFFFF, $urandom, 16'd1, {$urandom, $urandom}, 32'd0, 32'd0, 1, 0, 0);
      send_frame(5);
      build_frame(16'd0, $urandom, 16'd0, {$urandom, $urandom}, 32'd0, 32'd0, 1, 0, 0);
      send_frame(0);
      build_frame(16'd0, $urandom, 16'h8000, {$urandom, $urandom}, 32'd0, 32'd0, 1, 0, 0);
      send_frame(8);
      build_frame(16'd0, $urandom, 16'hFFFF, {$urandom, $urandom}, 32'd0, 32'd0, 1, 0, 0);
      send_frame(0);
      build_frame(16'd0, $urandom, 16'd1, {$urandom, $urandom}, 32'h8000_0000, 32'd0, 1, 2, 0);
      send_frame(0);
      build_frame(16'd0, $urandom, 16'd1, {$urandom, $urandom}, 32'hFFFF_FFFF, 32'd0, 1, 0, 0);
      send_frame(21);
      build_frame(16'd0, $urandom, 16'd1, {$urandom, $urandom}, 32'd1, 32'h8000_0000, 1, 1, 2);
      send_frame(0);
      build_frame(16'd0, $urandom, 16'd1, {$urandom, $urandom}, 32'd0, 32'hFFFF_FFFF, 1, 0, 0);
      send_frame(0);
      // Anything after a complete value is a length mismatch.
      build_clean_frame(1, 1, 1);
      put_noise(1);
      send_frame(0);
      build_clean_frame(1, 0, 0);
      put_noise(3);
      send_frame(0);
   endtask

   task automatic test_early_ends();
      int cuts[] = '{1, 2, 5, 6, 8, 9, 13, 18, 21, 22, 24, 27, 28, 29};
      // Layout with two-byte bodies: topic at 8, stamp at 10, key at 22,
      // value size at 24 and value bytes at 28.
      foreach (cuts[i]) begin
         build_clean_frame(2, 2, 2);
         send_frame(cuts[i]);
      end
      build_frame(16'd0, $urandom, 16'd1, {$urandom, $urandom},
                  32'h7FFF_FFFF, 32'd4, 1, 3, 0);
      send_frame(0);
      build_frame(16'd0, $urandom, 16'd1, {$urandom, $urandom},
                  32'd0, 32'h7FFF_FFFF, 1, 0, 5);
      send_frame(0);
   endtask

   // A topic longer than 255 bytes uses both bytes of the size field.
   task automatic test_long_topic();
      build_clean_frame(300, 2, 2);
      send_frame(0);
   endtask

   task automatic test_random_traffic();
      int goal;
      int pick;
      int tn;
      int kn;
      int vn;
      goal = parsed_bytes + RANDOM_BYTES;
      while (parsed_bytes < goal) begin
         pick = $urandom_range(0, 9);
         tn = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
         kn = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6);
         vn = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6);
         if (pick <= 5) begin
            build_clean_frame(tn, kn, vn);
            send_frame(0);
         end else if (pick == 6) begin
            build_clean_frame(tn, kn, vn);
            send_frame($urandom_range(1, frame_q.size()));
         end else if (pick == 7) begin
            build_clean_frame(tn, kn, vn);
            put_noise($urandom_range(1, 3));
            send_frame(0);
         end else if (pick == 8) begin
            case ($urandom_range(0, 3))
               0: build_frame(16'($urandom_range(1, 65535)), $urandom, 16'(tn),
                              {$urandom, $urandom}, 32'(kn), 32'(vn), tn, kn, vn);
               1: build_frame(16'd0, $urandom,
                              ($urandom_range(0, 1) != 0) ? 16'd0
                                 : 16'($urandom_range(16'h8000, 16'hFFFF)),
                              {$urandom, $urandom}, 32'(kn), 32'(vn), tn, kn, vn);
               2: build_frame(16'd0, $urandom, 16'(tn), {$urandom, $urandom},
                              $urandom | 32'h8000_0000, 32'(vn), tn, kn, vn);
               default: build_frame(16'd0, $urandom, 16'(tn), {$urandom, $urandom},
                                    32'(kn), $urandom | 32'h8000_0000, tn, kn, vn);
            endcase
            send_frame(($urandom_range(0, 1) != 0) ? 0
                                                   : $urandom_range(1, frame_q.size()));
         end else begin
            put_noise($urandom_range(1, 40));
            send_frame(0);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_clean_frames();
      test_header_errors();
      test_early_ends();
      test_long_topic();
      test_random_traffic();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
